@@ hw/rtl/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg
// Shared types, codes and constants of the voice allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int MAX_VOICES_DEF   = 16;
  localparam int MAX_VOICES_LIMIT = 64;

  localparam int VIDX_W  = $clog2(MAX_VOICES_LIMIT);
  localparam int VCNT_W  = $clog2(MAX_VOICES_LIMIT + 1);
  localparam int SCORE_W = 33;

  localparam logic [SCORE_W-1:0] PEN_REL  = SCORE_W'(2000);
  localparam logic [SCORE_W-1:0] PEN_SUST = SCORE_W'(1000);
  localparam logic [6:0]         PEDAL_ON_MIN = 7'd64;
  localparam logic [4:0]         CHG_MAX      = 5'd31;

  localparam logic CFG_ACTIVE_VOICES = 1'b0;
  localparam logic CFG_MONO_MODE     = 1'b1;

  typedef enum logic [2:0] {
    ACT_NOTE_ON       = 3'd0,
    ACT_NOTE_OFF      = 3'd1,
    ACT_SUSTAIN       = 3'd2,
    ACT_VOICE_DONE    = 3'd3,
    ACT_ALL_NOTES_OFF = 3'd4,
    ACT_ALL_SOUND_OFF = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_AVAIL = 2'd0,
    ST_ON    = 2'd1,
    ST_SUST  = 2'd2,
    ST_REL   = 2'd3
  } vstat_t;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_KEY_REL   = 3'd1,
    OP_NOTE_OFF  = 3'd2,
    OP_PEDAL_UP  = 3'd3,
    OP_FINISH    = 3'd4,
    OP_ALL_OFF   = 3'd5,
    OP_ALL_SOUND = 3'd6,
    OP_START     = 3'd7
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic                capture;
    logic [6:0]          key;
    logic                off_sust;
    logic                mono;
    logic [VIDX_W-1:0]   target;
    logic [31:0]         note_id;
    logic [VCNT_W-1:0]   scan_n;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] idx;
    logic              d_on;
    logic              d_cur;
  } cand_t;

  typedef struct packed {
    cand_t              avail;
    cand_t              steal;
    logic [SCORE_W-1:0] score;
    logic [VCNT_W-1:0]  count;
  } carry_t;

  function automatic logic [4:0] sat_count(input logic [VCNT_W-1:0] c);
    logic [4:0] r;
    if (c > VCNT_W'(CHG_MAX)) begin
      r = CHG_MAX;
    end else begin
      r = c[4:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/sva_cell.sv @@
// ----------------------------------------------------------------------------
// sva_cell
// One voice slot: status, key and note id, plus one stage of the candidate
// and change-count carry that ripples down the row of slots.
// ----------------------------------------------------------------------------
module sva_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  sva_pkg::cmd_t   cmd,
  input  sva_pkg::carry_t carry_in,
  output sva_pkg::carry_t carry_out
);
  import sva_pkg::*;

  localparam logic [VIDX_W-1:0] IDX_V = VIDX_W'(IDX);
  localparam logic [VCNT_W-1:0] IDX_N = VCNT_W'(IDX);

  vstat_t             status;
  vstat_t             status_next;
  vstat_t             orig;
  logic [6:0]         vkey;
  logic [31:0]        vnid;
  logic               en;
  logic               hit;
  logic               kmatch;
  logic               playing;
  logic               chg;
  logic [31:0]        age;
  logic [SCORE_W-1:0] pen;
  logic [SCORE_W-1:0] score;
  carry_t             carry_next;

  assign en      = IDX_N < cmd.scan_n;
  assign hit     = cmd.target == IDX_V;
  assign kmatch  = vkey == cmd.key;
  assign playing = (status == ST_ON) || (status == ST_SUST);
  assign chg     = status != orig;
  assign age     = cmd.note_id - vnid;
  assign score   = {1'b0, age} + pen;

  always_comb begin
    status_next = status;
    unique case (cmd.op)
      OP_NONE: ;
      OP_KEY_REL: begin
        if (en && kmatch && playing) status_next = ST_REL;
      end
      OP_NOTE_OFF: begin
        if (en && (cmd.mono ? playing : (status == ST_ON && kmatch))) begin
          status_next = cmd.off_sust ? ST_SUST : ST_REL;
        end
      end
      OP_PEDAL_UP: begin
        if (en && status == ST_SUST) status_next = ST_REL;
      end
      OP_FINISH: begin
        if (hit) status_next = ST_AVAIL;
      end
      OP_ALL_OFF: begin
        if (en && playing) status_next = ST_REL;
      end
      OP_ALL_SOUND: begin
        if (en) status_next = ST_AVAIL;
      end
      OP_START: begin
        if (hit) status_next = ST_ON;
      end
    endcase
  end

  always_comb begin
    unique case (status)
      ST_REL:  pen = PEN_REL;
      ST_SUST: pen = PEN_SUST;
      ST_AVAIL,
      ST_ON:   pen = '0;
    endcase
  end

  always_comb begin
    carry_next       = carry_in;
    carry_next.count = carry_in.count + VCNT_W'(chg);
    if (en && !carry_in.avail.valid && status == ST_AVAIL) begin
      carry_next.avail = '{valid: 1'b1, idx: IDX_V, d_on: (orig != ST_ON), d_cur: chg};
    end
    if (en && (!carry_in.steal.valid || score > carry_in.score)) begin
      carry_next.steal = '{valid: 1'b1, idx: IDX_V, d_on: (orig != ST_ON), d_cur: chg};
      carry_next.score = score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= ST_AVAIL;
    end else begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) orig <= status;
    if (cmd.op == OP_START && hit) begin
      vkey <= cmd.key;
      vnid <= cmd.note_id;
    end
    carry_out <= carry_next;
  end

endmodule

@@ hw/rtl/synth_voice_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit
// Polyphonic voice allocator with voice stealing, built as a row of voice
// slots with a rippling selection carry.
// ----------------------------------------------------------------------------
// Each event is accepted in the idle state and applied to all slots at
// once; then the free-voice / steal-candidate carry and the change count
// ripple one slot per cycle down the row; the write state then starts the
// note and loads the result register, waiting while that register holds an
// unread result, and returns to idle. A new event is taken only in idle.
// A result waiting in the output register does not block the next event
// until its own result is ready to be loaded. Configuration writes are
// taken in any cycle and must only be issued while no event is in flight.
module synth_voice_allocator_unit #(
  parameter int MAX_VOICES = sva_pkg::MAX_VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [6:0] key,
  input  logic [6:0] pedal_value,
  input  logic [3:0] finished_voice,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] voice_index,
  output logic       granted,
  output logic       stolen,
  output logic [4:0] voices_changed,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data
);
  import sva_pkg::*;

  localparam int CNT_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_VOICES - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_APPLY = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  action_t           act;
  logic [6:0]        key_q;
  logic [6:0]        pedal_q;
  logic [3:0]        fin_q;
  logic              sustain_held;
  logic [31:0]       next_note_id;
  logic [4:0]        active_voices;
  logic              mono_mode;
  logic [CNT_W-1:0]  scan_cnt;
  logic [VCNT_W-1:0] scan_n;
  logic              write_go;
  logic              note_start;
  cmd_t              cmd;
  cand_t             pick;
  logic [VCNT_W-1:0] adj;
  carry_t            chain [MAX_VOICES+1];

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign write_go  = (state == S_WRITE) && (!out_valid || out_ready);
  assign note_start = write_go && act == ACT_NOTE_ON;
  assign pick      = chain[MAX_VOICES].avail.valid ? chain[MAX_VOICES].avail
                                                   : chain[MAX_VOICES].steal;
  assign adj       = chain[MAX_VOICES].count + VCNT_W'(pick.d_on) - VCNT_W'(pick.d_cur);
  assign chain[0]  = '0;

  always_comb begin
    if (mono_mode || active_voices == '0) begin
      scan_n = VCNT_W'(1);
    end else if (VCNT_W'(active_voices) > VCNT_W'(MAX_VOICES)) begin
      scan_n = VCNT_W'(MAX_VOICES);
    end else begin
      scan_n = VCNT_W'(active_voices);
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.key      = key_q;
    cmd.off_sust = sustain_held;
    cmd.mono     = mono_mode;
    cmd.note_id  = next_note_id;
    cmd.scan_n   = scan_n;
    if (state == S_APPLY) begin
      cmd.capture = 1'b1;
      unique case (act)
        ACT_NOTE_ON:       cmd.op = mono_mode ? OP_NONE : OP_KEY_REL;
        ACT_NOTE_OFF:      cmd.op = OP_NOTE_OFF;
        ACT_SUSTAIN:       cmd.op = (pedal_q >= PEDAL_ON_MIN) ? OP_NONE : OP_PEDAL_UP;
        ACT_VOICE_DONE: begin
          cmd.op     = OP_FINISH;
          cmd.target = VIDX_W'(fin_q);
        end
        ACT_ALL_NOTES_OFF: cmd.op = OP_ALL_OFF;
        ACT_ALL_SOUND_OFF: cmd.op = OP_ALL_SOUND;
        default:           cmd.op = OP_NONE;
      endcase
    end else if (note_start) begin
      cmd.op     = OP_START;
      cmd.target = pick.idx;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_VOICES; g++) begin : g_cell
      sva_cell #(
        .IDX(g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .carry_in (chain[g]),
        .carry_out(chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_APPLY;
      S_APPLY: state_next = S_SCAN;
      S_SCAN:  if (scan_cnt == SCAN_LAST) state_next = S_WRITE;
      S_WRITE: if (write_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_cnt      <= '0;
      sustain_held  <= 1'b0;
      next_note_id  <= '0;
      active_voices <= 5'd16;
      mono_mode     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (state == S_APPLY) begin
        if (act == ACT_SUSTAIN) sustain_held <= pedal_q >= PEDAL_ON_MIN;
        if (act == ACT_ALL_NOTES_OFF) sustain_held <= 1'b0;
      end
      if (note_start) next_note_id <= next_note_id + 32'd1;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_VOICES: active_voices <= cfg_data;
          CFG_MONO_MODE:     mono_mode     <= cfg_data[0];
        endcase
      end
      if (write_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act     <= action_t'(action);
      key_q   <= key;
      pedal_q <= pedal_value;
      fin_q   <= finished_voice;
    end
    if (write_go) begin
      if (act == ACT_NOTE_ON) begin
        voice_index    <= 4'(pick.idx);
        granted        <= 1'b1;
        stolen         <= !chain[MAX_VOICES].avail.valid;
        voices_changed <= sat_count(adj);
      end else begin
        voice_index    <= '0;
        granted        <= 1'b0;
        stolen         <= 1'b0;
        voices_changed <= sat_count(chain[MAX_VOICES].count);
      end
    end
  end

`ifndef SYNTHESIS
  a_note_finds_voice: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE && act == ACT_NOTE_ON |->
      chain[MAX_VOICES].avail.valid || chain[MAX_VOICES].steal.valid)
    else $error("note on reached write with no candidate voice");

  a_stolen_needs_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && stolen |-> granted)
    else $error("stolen flag without grant");

  a_note_id_stable: assert property (@(posedge clk) disable iff (rst)
    !note_start |=> $stable(next_note_id))
    else $error("note id advanced without a note start");

  a_change_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(voices_changed) <= 32'(MAX_VOICES))
    else $error("change count exceeds voice count");
`endif

endmodule
